// File: rtl/ohbpa_pkg.sv
// ----------------------------------------------------------------------------
// ohbpa_pkg: shared types and constants of the OHLC bar period aggregator
// Field widths, bar and result records, the day-number divider constants and
// the record passed from the merge stage to the result queue.
// ----------------------------------------------------------------------------
package ohbpa_pkg;

    // Field widths
    localparam int TIME_W     = 45;
    localparam int PRICE_W    = 32;
    localparam int VOLUME_W   = 48;
    localparam int AMOUNT_W   = 63;
    localparam int INTEREST_W = 48;
    localparam int PERIOD_W   = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5);

    // Day number = bar_time / 1000000 = (bar_time >> 6) / 15625
    localparam int DAY_SHIFT = 6;
    localparam int Y_W       = TIME_W - DAY_SHIFT;          // 39
    localparam int Y_LO_W    = 20;
    localparam int Y_HI_W    = Y_W - Y_LO_W;                // 19
    localparam int DAY_W     = 26;
    localparam int RECIP_W   = 26;
    localparam int PLO_W     = Y_LO_W + RECIP_W;            // 46
    localparam int PHI_W     = Y_HI_W + RECIP_W;            // 45
    localparam int SUM_W     = PHI_W + Y_LO_W;              // 65
    localparam int QD_W      = DAY_W + 14;                  // 40
    localparam logic [13:0]        DAY_ODD   = 14'd15625;
    // floor(2^39 / 15625); the estimate it gives is low by at most one
    localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd35184372;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TIME_W-1:0]     time_stamp;
        logic [PRICE_W-1:0]    open_p;
        logic [PRICE_W-1:0]    high_p;
        logic [PRICE_W-1:0]    low_p;
        logic [PRICE_W-1:0]    close_p;
        logic [VOLUME_W-1:0]   volume;
        logic [AMOUNT_W-1:0]   amount;
        logic [PRICE_W-1:0]    average;
        logic [INTEREST_W-1:0] interest;
        logic [PRICE_W-1:0]    in_value;
        logic [PRICE_W-1:0]    time_value;
    } t_bar;

    typedef struct packed {
        t_bar bar;
        logic final_bar;
    } t_item;

    typedef struct packed {
        t_bar bar;
        logic last;
    } t_result;

    // Up to two results written into the queue in one cycle, first before second
    typedef struct packed {
        logic    first_v;
        logic    second_v;
        t_result first;
        t_result second;
    } t_push;

endpackage

// File: rtl/ohbpa_day_div.sv
// ----------------------------------------------------------------------------
// ohbpa_day_div: day-number pipeline
// Registers the incoming bar and carries it through five stages while its day
// number (bar_time / 1000000) is formed by reciprocal multiplication in two
// partial products, a recombining add and one correction step.
// ----------------------------------------------------------------------------
module ohbpa_day_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  ohbpa_pkg::t_item             i_item,
    output logic                         o_valid,
    input  logic                         i_take,
    output ohbpa_pkg::t_item             o_item,
    output logic [ohbpa_pkg::DAY_W-1:0]  o_day
);
    import ohbpa_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_v;
    t_item             r_item [STAGES];
    logic [STAGES-1:0] can_load;

    logic [PLO_W-1:0]  r_p_lo;
    logic [PHI_W-1:0]  r_p_hi;
    logic [DAY_W-1:0]  r_q0;
    logic [DAY_W-1:0]  r_q1;
    logic [QD_W-1:0]   r_qd;
    logic [DAY_W-1:0]  r_day;

    logic [Y_W-1:0]    y0;
    logic [Y_W-1:0]    y3;
    logic [SUM_W-1:0]  sum;
    logic [QD_W-1:0]   rem;

    // A stage may load when empty or when its contents move on
    always_comb begin
        can_load[STAGES-1] = !r_v[STAGES-1] || i_take;
        for (int i = STAGES - 2; i >= 0; i--) begin
            can_load[i] = !r_v[i] || can_load[i+1];
        end
    end

    assign y0  = r_item[0].bar.time_stamp[TIME_W-1:DAY_SHIFT];
    assign y3  = r_item[3].bar.time_stamp[TIME_W-1:DAY_SHIFT];
    assign sum = {r_p_hi, {Y_LO_W{1'b0}}} + SUM_W'(r_p_lo);
    assign rem = {1'b0, y3} - r_qd;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (can_load[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (can_load[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Advance payload and the divider terms
    always_ff @(posedge i_clk) begin
        if (can_load[0] && i_valid) begin
            r_item[0] <= i_item;
        end
        if (can_load[1] && r_v[0]) begin
            r_item[1] <= r_item[0];
            r_p_lo    <= PLO_W'(y0[Y_LO_W-1:0]) * PLO_W'(DAY_RECIP);
            r_p_hi    <= PHI_W'(y0[Y_W-1:Y_LO_W]) * PHI_W'(DAY_RECIP);
        end
        if (can_load[2] && r_v[1]) begin
            r_item[2] <= r_item[1];
            r_q0      <= sum[SUM_W-1:Y_W];
        end
        if (can_load[3] && r_v[2]) begin
            r_item[3] <= r_item[2];
            r_q1      <= r_q0;
            r_qd      <= QD_W'(r_q0) * QD_W'(DAY_ODD);
        end
        if (can_load[4] && r_v[3]) begin
            r_item[4] <= r_item[3];
            // correct the low estimate by one where the remainder overflows
            r_day     <= (rem >= QD_W'(DAY_ODD)) ? r_q1 + DAY_W'(1) : r_q1;
        end
    end

    assign o_stall = !can_load[0];
    assign o_valid = r_v[STAGES-1];
    assign o_item  = r_item[STAGES-1];
    assign o_day   = r_day;

endmodule

// File: rtl/ohbpa_merge.sv
// ----------------------------------------------------------------------------
// ohbpa_merge: bar accumulator
// Holds the open bar, the per-day bar counter and the period register, merges
// one source bar per cycle while there is room and queues up to two finished bars.
// ----------------------------------------------------------------------------
module ohbpa_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [ohbpa_pkg::PERIOD_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    input  ohbpa_pkg::t_item                i_item,
    input  logic [ohbpa_pkg::DAY_W-1:0]     i_day,
    input  logic                            i_room,
    output logic                            o_take,
    output ohbpa_pkg::t_push                o_push
);
    import ohbpa_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic                r_open;
    logic [PERIOD_W-1:0] r_cnt;
    logic [DAY_W-1:0]    r_acc_day;
    t_bar                r_acc;

    logic                n_open;
    logic [PERIOD_W-1:0] n_cnt;
    logic [DAY_W-1:0]    n_acc_day;
    t_bar                n_acc;

    t_bar                b;
    t_bar                merged;
    t_bar                loaded;
    logic                new_day;
    logic                full;

    assign b      = i_item.bar;
    assign o_take = i_valid && i_room;

    // Fold the new bar into the open one
    always_comb begin
        merged            = r_acc;
        merged.time_stamp = b.time_stamp;
        if (r_acc.open_p == '0) begin
            merged.open_p = b.open_p;
        end
        if (r_acc.high_p == '0 || b.high_p > r_acc.high_p) begin
            merged.high_p = b.high_p;
        end
        if (r_acc.low_p == '0 || b.low_p < r_acc.low_p) begin
            merged.low_p = b.low_p;
        end
        merged.close_p    = b.close_p;
        merged.volume     = r_acc.volume + b.volume;
        merged.amount     = r_acc.amount + b.amount;
        merged.average    = b.average;
        merged.interest   = b.interest;
        merged.in_value   = b.in_value;
        merged.time_value = b.time_value;
    end

    assign new_day = r_acc_day != i_day;
    assign full    = (r_cnt != '0) && (r_cnt >= r_period);

    // Decide what closes, what opens and what leaves
    always_comb begin
        n_open         = r_open;
        n_cnt          = r_cnt;
        n_acc_day      = r_acc_day;
        n_acc          = r_acc;
        loaded         = b;
        o_push         = '0;
        o_push.first   = '{bar: r_acc, last: 1'b0};
        o_push.second  = '{bar: b, last: i_item.final_bar};
        if (o_take) begin
            priority if (r_period == '0) begin
                // drop the bar, keep state
            end else if (r_period == PERIOD_W'(1)) begin
                o_push.first_v  = r_open;
                o_push.second_v = 1'b1;
                n_open          = 1'b0;
                n_cnt           = '0;
            end else begin
                priority if (!r_open) begin
                    loaded = b;
                    n_cnt  = '0;
                end else if (new_day || full) begin
                    o_push.first_v = 1'b1;
                    loaded         = b;
                    n_cnt          = new_day ? '0 : PERIOD_W'(1);
                end else begin
                    loaded = merged;
                    n_cnt  = r_cnt + PERIOD_W'(1);
                end
                n_acc     = loaded;
                n_acc_day = i_day;
                n_open    = 1'b1;
                // flush the open bar on the last source bar
                if (i_item.final_bar) begin
                    o_push.second_v = 1'b1;
                    o_push.second   = '{bar: loaded, last: 1'b1};
                    n_open          = 1'b0;
                    n_cnt           = '0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_open   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            r_open <= n_open;
            r_cnt  <= n_cnt;
        end
    end

    // Hold the open bar
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_acc_day <= n_acc_day;
    end

endmodule

// File: rtl/ohbpa_out_fifo.sv
// ----------------------------------------------------------------------------
// ohbpa_out_fifo: result queue
// Four-entry queue that takes one or two results per cycle and presents one
// result per cycle to the output channel while i_stall is low.
// ----------------------------------------------------------------------------
module ohbpa_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ohbpa_pkg::t_push    i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output ohbpa_pkg::t_result  o_head
);
    import ohbpa_pkg::*;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic             pop;
    logic [1:0]       n_push;
    logic [PTR_W-1:0] second_ptr;

    assign pop        = (r_count != '0) && !i_stall;
    assign n_push     = 2'(i_push.first_v) + 2'(i_push.second_v);
    assign second_ptr = i_push.first_v ? r_wr + PTR_W'(1) : r_wr;

    // Room for two more whatever leaves this cycle
    assign o_room  = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(n_push);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

    // Write results in order
    always_ff @(posedge i_clk) begin
        if (i_push.first_v) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.second_v) begin
            r_mem[second_ptr] <= i_push.second;
        end
    end

endmodule

// File: rtl/ohlc_bar_period_aggregator.sv
// ----------------------------------------------------------------------------
// ohlc_bar_period_aggregator: merges one-minute bars into period bars
// Day-number pipeline, bar accumulator and result queue.
//
//   channel   direction  handshake                   transfer when
//   input     in         i_valid / o_stall           i_valid && !o_stall
//   output    out        o_valid / i_stall           o_valid && !i_stall
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_valid && o_cfg_ready
//
// One source bar is taken every cycle while o_stall is low; a bar that gives
// two results needs two output transfers. After its input transfer the first
// result passes the remaining divider stages and the merge into the result
// queue before it is offered. Reset is synchronous and active low and restores
// a period of five. A stalled output lets the queue reach three or four
// entries, after which the divider stages fill and o_stall rises.
// ----------------------------------------------------------------------------
module ohlc_bar_period_aggregator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ohbpa_pkg::PERIOD_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ohbpa_pkg::TIME_W-1:0]       i_bar_time,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_open_price,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_high_price,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_low_price,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_close_price,
    input  logic [ohbpa_pkg::VOLUME_W-1:0]     i_traded_volume,
    input  logic [ohbpa_pkg::AMOUNT_W-1:0]     i_traded_amount,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_average_price,
    input  logic [ohbpa_pkg::INTEREST_W-1:0]   i_open_interest,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_in_value,
    input  logic [ohbpa_pkg::PRICE_W-1:0]      i_time_value,
    input  logic                               i_final_bar,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ohbpa_pkg::TIME_W-1:0]       o_out_time,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_open,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_high,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_low,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_close,
    output logic [ohbpa_pkg::VOLUME_W-1:0]     o_out_volume,
    output logic [ohbpa_pkg::AMOUNT_W-1:0]     o_out_amount,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_average,
    output logic [ohbpa_pkg::INTEREST_W-1:0]   o_out_interest,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_in_value,
    output logic [ohbpa_pkg::PRICE_W-1:0]      o_out_time_value,
    output logic                               o_last_of_stream
);
    import ohbpa_pkg::*;

    t_item            in_item;
    t_item            div_item;
    logic             div_valid;
    logic [DAY_W-1:0] div_day;
    logic             take;
    logic             room;
    t_push            push;
    t_result          head;

    // Gather the input fields
    assign in_item.bar.time_stamp = i_bar_time;
    assign in_item.bar.open_p     = i_open_price;
    assign in_item.bar.high_p     = i_high_price;
    assign in_item.bar.low_p      = i_low_price;
    assign in_item.bar.close_p    = i_close_price;
    assign in_item.bar.volume     = i_traded_volume;
    assign in_item.bar.amount     = i_traded_amount;
    assign in_item.bar.average    = i_average_price;
    assign in_item.bar.interest   = i_open_interest;
    assign in_item.bar.in_value   = i_in_value;
    assign in_item.bar.time_value = i_time_value;
    assign in_item.final_bar      = i_final_bar;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    ohbpa_day_div u_day_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .o_valid (div_valid),
        .i_take  (take),
        .o_item  (div_item),
        .o_day   (div_day)
    );

    ohbpa_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (div_valid),
        .i_item      (div_item),
        .i_day       (div_day),
        .i_room      (room),
        .o_take      (take),
        .o_push      (push)
    );

    ohbpa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    // Spread the head result over the output ports
    assign o_out_time       = head.bar.time_stamp;
    assign o_out_open       = head.bar.open_p;
    assign o_out_high       = head.bar.high_p;
    assign o_out_low        = head.bar.low_p;
    assign o_out_close      = head.bar.close_p;
    assign o_out_volume     = head.bar.volume;
    assign o_out_amount     = head.bar.amount;
    assign o_out_average    = head.bar.average;
    assign o_out_interest   = head.bar.interest;
    assign o_out_in_value   = head.bar.in_value;
    assign o_out_time_value = head.bar.time_value;
    assign o_last_of_stream = head.last;

endmodule

// File: rtl/ohbpa_checker.sv
// ----------------------------------------------------------------------------
// ohbpa_checker: port checks for the OHLC bar period aggregator
// Watches the top-level ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
module ohbpa_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic [ohbpa_pkg::TIME_W-1:0]       o_out_time,
    input  logic [ohbpa_pkg::VOLUME_W-1:0]     o_out_volume,
    input  logic                               o_last_of_stream
);
    import ohbpa_pkg::*;

    // A stalled result stays offered
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_time) && $stable(o_out_volume)
                               && $stable(o_last_of_stream))
        else $error("result payload changed while stalled");

    // Reset empties the result queue
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

    // Reset empties the input stages
    a_reset_ready : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled straight after reset");

endmodule

bind ohlc_bar_period_aggregator ohbpa_checker u_ohbpa_checker (.*);
